// File: src/khc_pkg.sv
`default_nettype none

package khc_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int KEY_W    = 32;
  localparam int CNT_W    = 32;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 7;

  localparam logic KIND_HIT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_COUNTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd5;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // One finished result on its way from the sequencer to the output stage.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [CNT_W-1:0]    count;
    logic [USED_W-1:0]   used;
  } res_t;

endpackage

`default_nettype wire

// File: src/khc_ram.sv
`default_nettype none

module khc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/khc_ctrl.sv
`default_nettype none

module khc_ctrl #(
  parameter int DEPTH = khc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [khc_pkg::KEY_W-1:0]     key,
  input  wire logic [khc_pkg::IDX_W-1:0]     index,
  output logic      [$clog2(DEPTH)-1:0]      rd_addr,
  output logic      [$clog2(DEPTH)-1:0]      wr_addr,
  output logic                               key_we,
  output logic      [khc_pkg::KEY_W-1:0]     key_wdata,
  output logic                               cnt_we,
  output logic      [khc_pkg::CNT_W-1:0]     cnt_wdata,
  input  wire logic [khc_pkg::KEY_W-1:0]     key_rdata,
  input  wire logic [khc_pkg::CNT_W-1:0]     cnt_rdata,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output khc_pkg::res_t                      res
);

  localparam int AW = $clog2(DEPTH);
  localparam int UW = $clog2(DEPTH + 1);
  localparam int CW = (UW > khc_pkg::IDX_W) ? UW : khc_pkg::IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                state;
  logic [UW-1:0]             used;
  logic [UW-1:0]             used_next;
  logic [AW-1:0]             ptr;
  logic [UW-1:0]             ptr_inc;
  logic [khc_pkg::KEY_W-1:0] hold_key;

  logic accept;
  logic is_hit_item;
  logic idx_ok;
  logic last;
  logic full;
  logic match;
  logic do_match;
  logic do_new;
  logic [khc_pkg::CNT_W-1:0] cnt_sat;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign is_hit_item = (kind == khc_pkg::KIND_HIT);
  assign idx_ok      = CW'(index) < CW'(used);
  assign ptr_inc     = UW'(ptr) + UW'(1);
  assign last        = (ptr_inc == used);
  assign full        = (used == UW'(DEPTH));
  assign match       = (key_rdata == hold_key);
  assign cnt_sat     = (cnt_rdata == khc_pkg::COUNT_MAX) ? cnt_rdata
                                                         : cnt_rdata + khc_pkg::CNT_W'(1);

  // An empty table needs no scan: a nonzero key is appended at once.
  assign do_match = (state == S_SCAN) && match;
  assign do_new   = ((state == S_SCAN) && !match && last && !full) ||
                    (accept && is_hit_item && (key != '0) && (used == '0));

  assign used_next = used + UW'(do_new);

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = is_hit_item ? '0 : AW'(index);
      S_SCAN:  rd_addr = AW'(ptr_inc);
      default: rd_addr = ptr;
    endcase
  end

  assign wr_addr   = do_match ? ptr : AW'(used);
  assign key_we    = do_new;
  assign key_wdata = (state == S_IDLE) ? key : hold_key;
  assign cnt_we    = do_new || do_match;
  assign cnt_wdata = do_match ? cnt_sat : khc_pkg::CNT_W'(1);

  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      used <= used_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            hold_key <= key;
            ptr      <= '0;
            res.used <= khc_pkg::USED_W'(used_next);
            if (!is_hit_item) begin
              if (idx_ok) begin
                state <= S_READ;
              end else begin
                res.status <= khc_pkg::ST_READ_EMPTY;
                res.key    <= '0;
                res.count  <= '0;
                state      <= S_DONE;
              end
            end else if (key == '0) begin
              res.status <= khc_pkg::ST_ZERO;
              res.key    <= '0;
              res.count  <= '0;
              state      <= S_DONE;
            end else if (used == '0) begin
              res.status <= khc_pkg::ST_NEW;
              res.key    <= key;
              res.count  <= khc_pkg::CNT_W'(1);
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_READ: begin
          res.status <= khc_pkg::ST_READ_OK;
          res.key    <= key_rdata;
          res.count  <= cnt_rdata;
          state      <= S_DONE;
        end
        S_SCAN: begin
          res.used <= khc_pkg::USED_W'(used_next);
          if (match) begin
            res.status <= khc_pkg::ST_COUNTED;
            res.key    <= hold_key;
            res.count  <= cnt_sat;
            state      <= S_DONE;
          end else if (last) begin
            if (full) begin
              res.status <= khc_pkg::ST_FULL;
              res.key    <= '0;
              res.count  <= '0;
            end else begin
              res.status <= khc_pkg::ST_NEW;
              res.key    <= hold_key;
              res.count  <= khc_pkg::CNT_W'(1);
            end
            state <= S_DONE;
          end else begin
            ptr <= ptr_inc[AW-1:0];
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/khc_out.sv
`default_nettype none

module khc_out (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             res_valid,
  output logic                                  res_ready,
  input  wire khc_pkg::res_t                    res,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [khc_pkg::STATUS_W-1:0]     status,
  output logic      [khc_pkg::KEY_W-1:0]        key_out,
  output logic      [khc_pkg::CNT_W-1:0]        count_out,
  output logic      [khc_pkg::USED_W-1:0]       entries_used
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= res.status;
      key_out      <= res.key;
      count_out    <= res.count;
      entries_used <= res.used;
    end
  end

endmodule

`default_nettype wire

// File: src/key_hit_count_table.sv
`default_nettype none

// Channel   Signals                              Direction
// input     in_valid/in_ready: kind key index    into the block
// output    out_valid/out_ready: status key_out  out of the block
//           count_out entries_used
//
// A hit beat scans the stored keys one per cycle through the key memory's
// read port, stopping at a match or after the last stored key; a read beat
// reads its entry through the same port, and key zero, an empty table or an
// out-of-range read go straight to the result. The next beat can be accepted
// in the cycle after the result moves into the output register.
// Reset is synchronous; it clears the fill count and the handshakes only.
// The key and count memories need no clearing, because no entry at or above
// the fill count is ever read out.
// A stalled output holds its beat while the next item is being processed.

module key_hit_count_table #(
  parameter int TABLE_DEPTH = khc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             kind,
  input  wire logic [khc_pkg::KEY_W-1:0]        key,
  input  wire logic [khc_pkg::IDX_W-1:0]        index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [khc_pkg::STATUS_W-1:0]     status,
  output logic      [khc_pkg::KEY_W-1:0]        key_out,
  output logic      [khc_pkg::CNT_W-1:0]        count_out,
  output logic      [khc_pkg::USED_W-1:0]       entries_used
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // Both memories share one address on each port; entry i of the key memory
  // pairs with entry i of the count memory.
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  logic                          key_we;
  logic [khc_pkg::KEY_W-1:0]     key_wdata;
  logic                          cnt_we;
  logic [khc_pkg::CNT_W-1:0]     cnt_wdata;
  logic [khc_pkg::KEY_W-1:0]     key_rdata;
  logic [khc_pkg::CNT_W-1:0]     cnt_rdata;

  logic          res_valid;
  logic          res_ready;
  khc_pkg::res_t res;

  khc_ram #(
    .WIDTH (khc_pkg::KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  khc_ram #(
    .WIDTH (khc_pkg::CNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (wr_addr),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  // The sequencer owns the fill count and walks the memories; all writes
  // for an item land before the next item can be accepted, so no read ever
  // overlaps a pending write to the same entry.
  khc_ctrl #(
    .DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .key       (key),
    .index     (index),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .key_we    (key_we),
    .key_wdata (key_wdata),
    .cnt_we    (cnt_we),
    .cnt_wdata (cnt_wdata),
    .key_rdata (key_rdata),
    .cnt_rdata (cnt_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: decouples the downstream stall from the sequencer.
  khc_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .key_out      (key_out),
    .count_out    (count_out),
    .entries_used (entries_used)
  );

endmodule

`default_nettype wire

// File: src/khc_checker.sv
`default_nettype none

module khc_checker #(
  parameter int DEPTH = khc_pkg::TABLE_DEPTH_DEFAULT
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [khc_pkg::STATUS_W-1:0] status,
  input wire logic [khc_pkg::KEY_W-1:0]    key_out,
  input wire logic [khc_pkg::CNT_W-1:0]    count_out,
  input wire logic [khc_pkg::USED_W-1:0]   entries_used
);

  // The block works on one item at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(key_out) && $stable(count_out) && $stable(entries_used))
    else $error("stalled result beat changed");

  // Results that name no entry carry zero key and count.
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == khc_pkg::ST_FULL || status == khc_pkg::ST_ZERO ||
      status == khc_pkg::ST_READ_EMPTY) |-> key_out == '0 && count_out == '0)
    else $error("nonzero fields on an empty result");

  // Stored counts start at one and saturate, so a live entry never shows zero.
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == khc_pkg::ST_COUNTED || status == khc_pkg::ST_NEW ||
      status == khc_pkg::ST_READ_OK) |-> count_out != '0 && entries_used != '0)
    else $error("live entry with zero count or empty table");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH >= 128) || (32'(entries_used) <= 32'(DEPTH)))
    else $error("fill count beyond table depth");

endmodule

bind key_hit_count_table khc_checker #(
  .DEPTH (TABLE_DEPTH)
) u_khc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .key_out      (key_out),
  .count_out    (count_out),
  .entries_used (entries_used)
);

`default_nettype wire

// File: tb/hit_table_checker.sv
`timescale 1ns / 100ps

module hit_table_checker #(
  parameter int TABLE_DEPTH = khc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic                         kind,
  input  wire logic [khc_pkg::KEY_W-1:0]    key,
  input  wire logic [khc_pkg::IDX_W-1:0]    index,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [khc_pkg::STATUS_W-1:0] status,
  input  wire logic [khc_pkg::KEY_W-1:0]    key_out,
  input  wire logic [khc_pkg::CNT_W-1:0]    count_out,
  input  wire logic [khc_pkg::USED_W-1:0]   entries_used,
  output int                                mismatches,
  output int                                owed,
  output int                                n_counted,
  output int                                n_new,
  output int                                n_full,
  output int                                n_zero,
  output int                                n_read_ok,
  output int                                n_read_empty,
  output int                                table_fill
);

  // Shadow copy of the table: only entries below table_fill are ever valid.
  logic [khc_pkg::KEY_W-1:0] stored_key [TABLE_DEPTH];
  logic [khc_pkg::CNT_W-1:0] stored_count [TABLE_DEPTH];

  khc_pkg::res_t owed_results [$];

  // Applies one accepted beat to the shadow table and returns its result.
  function automatic khc_pkg::res_t apply_table_beat(input logic                      kind_b,
                                                     input logic [khc_pkg::KEY_W-1:0] key_b,
                                                     input logic [khc_pkg::IDX_W-1:0] idx_b);
    khc_pkg::res_t r;
    int slot;
    int i;
    r = '0;
    slot = -1;
    if (kind_b == khc_pkg::KIND_READ) begin
      if (int'(idx_b) < table_fill && int'(idx_b) < TABLE_DEPTH) begin
        r.status = khc_pkg::ST_READ_OK;
        r.key    = stored_key[idx_b];
        r.count  = stored_count[idx_b];
      end else begin
        r.status = khc_pkg::ST_READ_EMPTY;
      end
    end else if (key_b == '0) begin
      r.status = khc_pkg::ST_ZERO;
    end else begin
      for (i = 0; i < table_fill; i++) begin
        if (slot < 0 && stored_key[i] == key_b) slot = i;
      end
      if (slot >= 0) begin
        if (stored_count[slot] != khc_pkg::COUNT_MAX) stored_count[slot] += 1;
        r.status = khc_pkg::ST_COUNTED;
        r.key    = key_b;
        r.count  = stored_count[slot];
      end else if (table_fill >= TABLE_DEPTH) begin
        r.status = khc_pkg::ST_FULL;
      end else begin
        stored_key[table_fill]   = key_b;
        stored_count[table_fill] = 1;
        table_fill               = table_fill + 1;
        r.status = khc_pkg::ST_NEW;
        r.key    = key_b;
        r.count  = 1;
      end
    end
    r.used = table_fill[khc_pkg::USED_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    khc_pkg::res_t want;
    khc_pkg::res_t got;
    if (rst) begin
      owed_results.delete();
      table_fill   = 0;
      mismatches   = 0;
      n_counted    = 0;
      n_new        = 0;
      n_full       = 0;
      n_zero       = 0;
      n_read_ok    = 0;
      n_read_empty = 0;
    end else begin
      // A result never leaves on the edge its beat arrives, so this order is safe.
      if (in_valid && in_ready) owed_results.push_back(apply_table_beat(kind, key, index));
      if (out_valid && out_ready) begin
        got = {status, key_out, count_out, entries_used};
        if (owed_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing owed: status %0d key %h count %h used %0d",
                     $time, got.status, got.key, got.count, got.used);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected status %0d key %h count %h used %0d, got status %0d key %h count %h used %0d",
                       $time, want.status, want.key, want.count, want.used,
                       got.status, got.key, got.count, got.used);
            mismatches++;
          end
          case (want.status)
            khc_pkg::ST_COUNTED: n_counted++;
            khc_pkg::ST_NEW:     n_new++;
            khc_pkg::ST_FULL:    n_full++;
            khc_pkg::ST_ZERO:    n_zero++;
            khc_pkg::ST_READ_OK: n_read_ok++;
            default:             n_read_empty++;
          endcase
        end
      end
    end
    owed = owed_results.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_DEPTH  = khc_pkg::TABLE_DEPTH_DEFAULT;
  // The tail wait covers the longest hit scan with room to spare.
  localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 20;
  // The run is roughly 1000 beats, each paying for a scan, a sender gap and a receiver stall;
  // the limit is set well above the slowest such run.
  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 300;
  localparam int RANDOM_BEATS = 880;
  localparam int POOL_SIZE    = 96;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic                         kind;
  logic [khc_pkg::KEY_W-1:0]    key;
  logic [khc_pkg::IDX_W-1:0]    index;
  logic                         out_valid;
  logic                         out_ready;
  logic [khc_pkg::STATUS_W-1:0] status;
  logic [khc_pkg::KEY_W-1:0]    key_out;
  logic [khc_pkg::CNT_W-1:0]    count_out;
  logic [khc_pkg::USED_W-1:0]   entries_used;

  int mismatches;
  int owed;
  int n_counted;
  int n_new;
  int n_full;
  int n_zero;
  int n_read_ok;
  int n_read_empty;
  int table_fill;

  int cycle_count = 0;
  int beats_sent  = 0;
  int burst_left  = 0;
  bit hold_off    = 1'b0;

  // Keys the random part draws from; a growing window of it fills the table
  // slowly, so repeats, first sightings and full-table drops all show up.
  logic [khc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  // Every distinct nonzero key offered so far, used to aim reads at filled entries.
  logic [khc_pkg::KEY_W-1:0] keys_offered [$];

  key_hit_count_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .key         (key),
    .index       (index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .key_out     (key_out),
    .count_out   (count_out),
    .entries_used(entries_used)
  );

  hit_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .key         (key),
    .index       (index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .key_out     (key_out),
    .count_out   (count_out),
    .entries_used(entries_used),
    .mismatches  (mismatches),
    .owed        (owed),
    .n_counted   (n_counted),
    .n_new       (n_new),
    .n_full      (n_full),
    .n_zero      (n_zero),
    .n_read_ok   (n_read_ok),
    .n_read_empty(n_read_empty),
    .table_fill  (table_fill)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results still owed", cycle_count, owed);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bit key_known(input logic [khc_pkg::KEY_W-1:0] kv);
    foreach (keys_offered[i]) begin
      if (keys_offered[i] == kv) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int fill_guess();
    return (keys_offered.size() < TABLE_DEPTH) ? keys_offered.size() : TABLE_DEPTH;
  endfunction

  // Offers one beat, holds it until accepted, then closes the burst with a
  // random gap when the burst runs out. Some gaps are zero, so back-to-back
  // bursts give long stretches with no idling on the input.
  task automatic send_item(input logic k, input logic [khc_pkg::KEY_W-1:0] kv,
                           input logic [khc_pkg::IDX_W-1:0] iv);
    int gap;
    kind     = k;
    key      = kv;
    index    = iv;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (k == khc_pkg::KIND_HIT && kv != '0 && !key_known(kv)) keys_offered.push_back(kv);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Receiver: switches its stall pattern at random intervals between always
  // ready, mostly ready and mostly stalled. The long hold-off overrides it.
  initial begin
    int mode_left;
    int ready_pct;
    out_ready = 1'b0;
    mode_left = 0;
    ready_pct = 100;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 2))
          0: begin
            ready_pct = 100;
          end
          1: begin
            ready_pct = 70;
          end
          default: begin
            ready_pct = 25;
          end
        endcase
      end
      mode_left--;
      out_ready = !hold_off && ($urandom_range(1, 100) <= ready_pct);
      @(negedge clk);
    end
  end

  // Long hold-off: once the run is under way, the receiver refuses results for
  // a long stretch while the sender keeps offering, so the block backs up and
  // drops in_ready. The flag moves on rising edges and is read on falling ones.
  initial begin
    while (beats_sent < HOLD_AFTER) @(negedge clk);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int n;
    int reach;
    int pick;
    int fill;
    logic [khc_pkg::KEY_W-1:0] junk_key;
    logic [khc_pkg::IDX_W-1:0] junk_idx;

    rst      = 1'b1;
    in_valid = 1'b0;
    kind     = khc_pkg::KIND_HIT;
    key      = '0;
    index    = '0;
    for (n = 0; n < POOL_SIZE; n++) begin
      key_pool[n] = $urandom;
      if (key_pool[n] == '0) key_pool[n] = n + 1;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Reads on an empty table, the zero key, the all-ones and
    // single-bit keys, repeat hits, reads on both sides of the fill line, and
    // don't-care fields set to their extremes.
    send_item(khc_pkg::KIND_READ, '0, '0);
    send_item(khc_pkg::KIND_READ, '1, '1);
    send_item(khc_pkg::KIND_HIT, '0, '0);
    send_item(khc_pkg::KIND_HIT, '1, '0);
    send_item(khc_pkg::KIND_HIT, '1, '1);
    send_item(khc_pkg::KIND_HIT, 32'h0000_0001, '0);
    send_item(khc_pkg::KIND_HIT, 32'h8000_0000, '1);
    send_item(khc_pkg::KIND_HIT, '1, '0);
    send_item(khc_pkg::KIND_READ, '0, 6'd0);
    send_item(khc_pkg::KIND_READ, '1, 6'd2);
    send_item(khc_pkg::KIND_READ, '0, 6'd3);
    send_item(khc_pkg::KIND_READ, '0, '1);
    send_item(khc_pkg::KIND_HIT, '0, '1);
    send_item(khc_pkg::KIND_HIT, 32'h5555_5555, 6'h2A);
    send_item(khc_pkg::KIND_HIT, 32'hAAAA_AAAA, 6'h15);
    send_item(khc_pkg::KIND_HIT, 32'h0000_0001, '0);
    send_item(khc_pkg::KIND_READ, 32'h1234_5678, 6'd1);
    send_item(khc_pkg::KIND_READ, '0, 6'd4);
    send_item(khc_pkg::KIND_READ, '0, 6'd5);

    // Random part: mostly hits from the pool window, which widens past the
    // table size so the table fills and later new keys are dropped. The rest
    // is zero keys, fully random keys, and reads aimed inside and anywhere.
    for (n = 0; n < RANDOM_BEATS; n++) begin
      reach    = 8 + (n * (POOL_SIZE - 8)) / RANDOM_BEATS;
      pick     = $urandom_range(0, 99);
      junk_key = $urandom;
      junk_idx = khc_pkg::IDX_W'($urandom_range(0, 63));
      fill     = fill_guess();
      if (pick < 55)
        send_item(khc_pkg::KIND_HIT, key_pool[$urandom_range(0, reach - 1)], junk_idx);
      else if (pick < 60)
        send_item(khc_pkg::KIND_HIT, '0, junk_idx);
      else if (pick < 64)
        send_item(khc_pkg::KIND_HIT, junk_key, junk_idx);
      else if (pick < 85 && fill > 0)
        send_item(khc_pkg::KIND_READ, junk_key,
                  khc_pkg::IDX_W'($urandom_range(0, fill - 1)));
      else
        send_item(khc_pkg::KIND_READ, junk_key, junk_idx);
    end

    // Unload listing: read every index in order.
    for (n = 0; n < TABLE_DEPTH; n++) send_item(khc_pkg::KIND_READ, $urandom, khc_pkg::IDX_W'(n));
    in_valid = 1'b0;

    while (owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d beats: %0d counted, %0d new, %0d dropped full, %0d zero keys, %0d reads ok, %0d reads empty",
             beats_sent, n_counted, n_new, n_full, n_zero, n_read_ok, n_read_empty);
    $display("Table ended with %0d of %0d entries in use; output held off once for %0d cycles",
             table_fill, TABLE_DEPTH, HOLD_CYCLES);
    if (mismatches == 0 && owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, owed);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
